FILE: sv/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, codes, types and helpers of the transition sampler.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int NUM_STATES_DEF = 8;
	localparam int MAX_TRANS_DEF  = 8;

	localparam int WEIGHT_W = 7;
	localparam logic [7:0] PCT_MAX = 8'd100;

	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_ADVANCE = 2'd1;
	localparam logic [1:0] REQ_SET     = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PERCENT = 3'd1;
	localparam logic [2:0] ST_SUM     = 3'd2;
	localparam logic [2:0] ST_NONE    = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic       hit;
		logic       over;
		logic [7:0] sum;
	} band_t;

	// reduce a 3-bit state index modulo n (n >= 2)
	function automatic logic [8:0] wrap_idx(input logic [2:0] v, input logic [8:0] n);
		logic [8:0] r;
		r = {6'd0, v};
		for (int k = 0; k < 4; k++) begin
			if (r >= n) begin
				r = r - n;
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/mts_band.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_band
// Shared add and compare unit: running sum plus weight, band hit, sum limit.
// ----------------------------------------------------------------------------
module mts_band (
	input  logic [mts_pkg::WEIGHT_W-1:0] base,
	input  logic [mts_pkg::WEIGHT_W-1:0] weight,
	input  logic [6:0]                   draw,
	output mts_pkg::band_t               res
);
	import mts_pkg::*;

	always_comb begin
		res.sum  = {1'b0, base} + {1'b0, weight};
		res.over = res.sum > PCT_MAX;
		res.hit  = (base <= draw) && ({1'b0, draw} < res.sum);
	end

endmodule

FILE: sv/markov_transition_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_sampler_unit
// Markov chain with percent weights: add transitions, set state, advance.
//
// channel  dir  tdata (lsb up)                                  tuser
// s_axis   in   from_state, to_state, percent, random_value     req_type
// m_axis   out  executed_state, next_state, status              -
//
// Add, set and unused requests pass through exec to finish, where the
// result is registered. Advance walks up to MAX_TRANS entries of the
// current state's list in between, one table read and one band check a
// cycle through the shared add/compare unit.
// Reset clears counts, sums and current state at once; no clearing pass.
// A result held in the output register stalls only the final step.
// ----------------------------------------------------------------------------
module markov_transition_sampler_unit #(
	parameter int NUM_STATES = mts_pkg::NUM_STATES_DEF,
	parameter int MAX_TRANS  = mts_pkg::MAX_TRANS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // from_state, to_state, percent, random_value
	input  logic [1:0]  s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // executed_state, next_state, status
);
	import mts_pkg::*;

	localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int DEPTH = NUM_STATES * MAX_TRANS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
	localparam int CW    = $clog2(MAX_TRANS + 1);
	localparam int RW    = SW + WEIGHT_W;
	localparam logic [8:0] NS9 = 9'(NUM_STATES);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_WALK   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	logic [1:0]          req_q;
	logic [SW-1:0]       src_q, dst_q, cur_q;
	logic [7:0]          pct_q;
	logic [6:0]          draw_q;
	logic [IW-1:0]       idx_q;
	logic [WEIGHT_W-1:0] cum_q;
	logic [CW-1:0]       cnt_q  [NUM_STATES];
	logic [WEIGHT_W-1:0] wsum_q [NUM_STATES];
	logic [2:0]          res_exec_q, res_status_q;
	logic                out_valid_q;
	logic [2:0]          out_exec_q, out_next_q, out_status_q;

	logic [SW-1:0]       row;
	logic [CW-1:0]       cnt_row;
	logic [WEIGHT_W-1:0] wsum_row;
	logic [AW-1:0]       base, offset, addr;
	logic                ram_we;
	logic [RW-1:0]       ram_rdata;
	logic [SW-1:0]       rd_target;
	logic [WEIGHT_W-1:0] rd_weight;
	logic [WEIGHT_W-1:0] band_a, band_b;
	band_t               band;
	logic                pct_bad, full, last;
	logic [8:0]          cur9, from9, to9;
	logic                load_out;

	assign from9 = wrap_idx(s_axis_tdata[2:0], NS9);
	assign to9   = wrap_idx(s_axis_tdata[5:3], NS9);
	assign cur9  = 9'(cur_q);

	assign row      = (req_q == REQ_ADD) ? src_q : cur_q;
	assign cnt_row  = cnt_q[row];
	assign wsum_row = wsum_q[row];

	assign pct_bad = pct_q > PCT_MAX;
	assign full    = cnt_row >= CW'(MAX_TRANS);
	assign last    = (CW'(idx_q) + CW'(1)) == cnt_row;

	assign load_out = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);

	assign {rd_target, rd_weight} = ram_rdata;

	assign band_a = (state_q == S_WALK) ? cum_q : wsum_row;
	assign band_b = (state_q == S_WALK) ? rd_weight : pct_q[WEIGHT_W-1:0];

	mts_band u_band (
		.base   (band_a),
		.weight (band_b),
		.draw   (draw_q),
		.res    (band)
	);

	assign ram_we = (state_q == S_EXEC) && (req_q == REQ_ADD) && !pct_bad && !full
		&& !band.over;

	always_comb begin
		base = AW'(row) * AW'(MAX_TRANS);
		if (state_q == S_EXEC && req_q == REQ_ADD) begin
			offset = AW'(cnt_row);
		end else if (state_q == S_EXEC) begin
			offset = '0;
		end else begin
			offset = AW'(idx_q) + AW'(1);
		end
		addr = base + offset;
	end

	mts_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata ({dst_q, pct_q[WEIGHT_W-1:0]}),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			out_valid_q  <= 1'b0;
			req_q        <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			pct_q        <= '0;
			draw_q       <= '0;
			idx_q        <= '0;
			cum_q        <= '0;
			res_exec_q   <= '0;
			res_status_q <= '0;
			out_exec_q   <= '0;
			out_next_q   <= '0;
			out_status_q <= '0;
			for (int i = 0; i < NUM_STATES; i++) begin
				cnt_q[i]  <= '0;
				wsum_q[i] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q   <= s_axis_tuser;
						src_q   <= SW'(from9);
						dst_q   <= SW'(to9);
						pct_q   <= s_axis_tdata[13:6];
						draw_q  <= s_axis_tdata[20:14];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_exec_q   <= '0;
					res_status_q <= ST_OK;
					state_q      <= S_FINISH;
					case (req_q)
						REQ_ADD: begin
							if (pct_bad) begin
								res_status_q <= ST_PERCENT;
							end else if (full) begin
								res_status_q <= ST_FULL;
							end else if (band.over) begin
								res_status_q <= ST_SUM;
							end else begin
								cnt_q[src_q]  <= cnt_row + CW'(1);
								wsum_q[src_q] <= band.sum[WEIGHT_W-1:0];
							end
						end
						REQ_ADVANCE: begin
							res_exec_q <= cur9[2:0];
							idx_q      <= '0;
							cum_q      <= '0;
							if (cnt_row == '0) begin
								res_status_q <= ST_NONE;
							end else begin
								state_q <= S_WALK;
							end
						end
						REQ_SET: begin
							cur_q <= dst_q;
						end
						default: begin
						end
					endcase
				end
				S_WALK: begin
					if (band.hit) begin
						cur_q   <= rd_target;
						state_q <= S_FINISH;
					end else begin
						cum_q <= band.sum[WEIGHT_W-1:0];
						if (last) begin
							res_status_q <= ST_NONE;
							state_q      <= S_FINISH;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_FINISH: begin
					if (load_out) begin
						out_exec_q   <= res_exec_q;
						out_next_q   <= cur9[2:0];
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_status_q, out_next_q, out_exec_q};

	a_we_only_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_EXEC && req_q == REQ_ADD))
		else $error("table write outside an add");

	a_sum_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> wsum_q[$past(src_q)] <= WEIGHT_W'(PCT_MAX))
		else $error("weight sum above limit");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (CW'(idx_q) < cnt_q[cur_q]))
		else $error("walk beyond list");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside finish");

endmodule

FILE: tb/markov_sampler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_sampler_checker
// Watches both stream channels of the transition sampler. Every accepted
// request is run through a local model of the chain tables. The outcome it
// predicts is queued, and each delivered result is compared field by field
// with the oldest outcome in the queue.
// ----------------------------------------------------------------------------
module markov_sampler_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // from_state, to_state, percent, random_value
	input  logic [1:0]  s_axis_tuser,  // req_type
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // executed_state, next_state, status
	output int          mismatch_count,
	output int          pending
);
	import mts_pkg::*;

	localparam int NODES       = NUM_STATES_DEF;
	localparam int CHAIN_DEPTH = MAX_TRANS_DEF;

	typedef struct packed {
		logic [2:0] executed;
		logic [2:0] next;
		logic [2:0] status;
	} chain_outcome_t;

	logic [2:0] dest_of   [NODES][CHAIN_DEPTH];
	logic [6:0] weight_of [NODES][CHAIN_DEPTH];
	logic [3:0] fill      [NODES];
	logic [6:0] wsum      [NODES];
	logic [2:0] cur;

	chain_outcome_t outcome_q[$];
	int fault_tally = 0;
	int result_idx  = 0;

	assign mismatch_count = fault_tally;

	task automatic note_mismatch(input string field, input int got, input int want);
		$display("checker: result %0d %s got %0d want %0d at %0t",
			result_idx, field, got, want, $realtime);
		fault_tally++;
	endtask

	// 3-bit state fields against 8 states: modulo reduction is the identity
	function automatic chain_outcome_t predict_outcome(input logic [1:0] req,
			input logic [2:0] src, input logic [2:0] dst,
			input logic [7:0] pct, input logic [6:0] draw);
		chain_outcome_t o;
		logic [2:0] origin;
		int n;
		int cum;
		logic hit;
		o = '0;
		o.status = ST_OK;
		case (req)
			REQ_ADD: begin
				if (pct > PCT_MAX) begin
					o.status = ST_PERCENT;
				end else if (int'(fill[src]) >= CHAIN_DEPTH) begin
					o.status = ST_FULL;
				end else if (int'(wsum[src]) + int'(pct) > int'(PCT_MAX)) begin
					o.status = ST_SUM;
				end else begin
					dest_of[src][fill[src]]   = dst;
					weight_of[src][fill[src]] = pct[6:0];
					wsum[src] = wsum[src] + pct[6:0];
					fill[src] = fill[src] + 4'd1;
				end
			end
			REQ_ADVANCE: begin
				origin = cur;
				n = int'(fill[origin]);
				o.executed = origin;
				cum = 0;
				hit = 1'b0;
				for (int i = 0; i < n; i++) begin
					if (!hit) begin
						if (int'(draw) >= cum && int'(draw) < cum + int'(weight_of[origin][i])) begin
							cur = dest_of[origin][i];
							hit = 1'b1;
						end
						cum += int'(weight_of[origin][i]);
					end
				end
				if (!hit) begin
					o.status = ST_NONE;
				end
			end
			REQ_SET: begin
				cur = dst;
			end
			default: ;
		endcase
		o.next = cur;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chain_outcome_t want;
		if (!arst_n) begin
			for (int s = 0; s < NODES; s++) begin
				fill[s] = '0;
				wsum[s] = '0;
			end
			cur = '0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (outcome_q.size() == 0) begin
					note_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = outcome_q.pop_front();
					if (m_axis_tdata[2:0] !== want.executed)
						note_mismatch("executed_state", m_axis_tdata[2:0], want.executed);
					if (m_axis_tdata[5:3] !== want.next)
						note_mismatch("next_state", m_axis_tdata[5:3], want.next);
					if (m_axis_tdata[8:6] !== want.status)
						note_mismatch("status", m_axis_tdata[8:6], want.status);
					if (m_axis_tdata[15:9] !== 7'd0)
						note_mismatch("padding", m_axis_tdata[15:9], 0);
				end
				result_idx++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				outcome_q.insert(outcome_q.size(), predict_outcome(s_axis_tuser,
					s_axis_tdata[2:0], s_axis_tdata[5:3], s_axis_tdata[13:6],
					s_axis_tdata[20:14]));
			end
			pending <= outcome_q.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, set, advance and unused requests into the sampler: a short
// directed run over the rejection codes, zero weights, out-of-band draws and
// a full list, then random bursts that fill and walk the chain tables. The
// result side stalls in changing patterns. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import mts_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // from_state, to_state, percent, random_value
	logic [1:0]  s_axis_tuser = '0;  // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // executed_state, next_state, status

	int mismatch_count;
	int pending;

	logic [15:0] rx_tick = '0;
	logic [1:0]  rx_mode = '0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	markov_transition_sampler_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	markov_sampler_checker u_watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// result side: the ready pattern changes on a free-running tick counter
	always @(negedge clk) begin
		rx_tick <= rx_tick + 16'd1;
		if (rx_tick[5:0] == 6'd0) begin
			rx_mode <= 2'($urandom_range(0, 3));
		end
		case (rx_mode)
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= (rx_tick[1:0] == 2'd0);
			2'd2: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= rx_tick[3];
		endcase
	end

	task automatic push_request(input logic [1:0] req, input logic [2:0] src,
			input logic [2:0] dst, input logic [7:0] pct, input logic [6:0] draw);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {3'b000, draw, pct, dst, src};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	initial begin
		int sent;
		int burst;
		int r;
		int k;
		logic [1:0] req;
		logic [2:0] src;
		logic [2:0] dst;
		logic [7:0] pct;
		logic [6:0] draw;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// empty list, bad weights, zero weight, sum overflow, then draws in and out of band
		push_request(REQ_ADVANCE, 3'd0, 3'd0, 8'd0, 7'd50);
		push_request(REQ_ADD, 3'd0, 3'd4, 8'd101, 7'd0);
		push_request(REQ_ADD, 3'd0, 3'd4, 8'd255, 7'd0);
		push_request(REQ_ADD, 3'd0, 3'd3, 8'd0, 7'd0);
		push_request(REQ_ADD, 3'd0, 3'd5, 8'd40, 7'd0);
		push_request(REQ_ADD, 3'd0, 3'd7, 8'd60, 7'd0);
		push_request(REQ_ADD, 3'd0, 3'd1, 8'd1, 7'd0);
		push_request(REQ_ADVANCE, 3'd0, 3'd0, 8'd0, 7'd0);
		push_request(REQ_SET, 3'd0, 3'd0, 8'd0, 7'd0);
		push_request(REQ_ADVANCE, 3'd0, 3'd0, 8'd0, 7'd99);
		push_request(REQ_SET, 3'd0, 3'd0, 8'd0, 7'd0);
		push_request(REQ_ADVANCE, 3'd0, 3'd0, 8'd0, 7'd100);
		push_request(REQ_ADVANCE, 3'd0, 3'd0, 8'd0, 7'd127);
		// fill state 7, then overflow the list
		for (int i = 0; i < MAX_TRANS_DEF; i++) begin
			push_request(REQ_ADD, 3'd7, 3'(i), 8'd12, 7'd0);
		end
		push_request(REQ_ADD, 3'd7, 3'd0, 8'd0, 7'd0);
		push_request(REQ_SET, 3'd0, 3'd7, 8'd0, 7'd0);
		push_request(REQ_ADVANCE, 3'd0, 3'd0, 8'd0, 7'd95);
		push_request(REQ_UNUSED, 3'd5, 3'd2, 8'd77, 7'd33);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				r    = $urandom_range(0, 19);
				src  = 3'($urandom);
				dst  = 3'($urandom);
				pct  = 8'($urandom);
				draw = 7'($urandom);
				if (r < 6) begin
					req = REQ_ADD;
					k = $urandom_range(0, 9);
					if (k < 6) pct = 8'($urandom_range(0, 25));
					else if (k < 8) pct = 8'($urandom_range(0, 100));
					else if (k < 9) pct = 8'($urandom_range(101, 255));
					else pct = 8'd0;
				end else if (r < 15) begin
					req = REQ_ADVANCE;
					if ($urandom_range(0, 6) == 0) draw = 7'($urandom_range(100, 127));
					else draw = 7'($urandom_range(0, 99));
				end else if (r < 19) begin
					req = REQ_SET;
				end else begin
					req = REQ_UNUSED;
				end
				push_request(req, src, dst, pct, draw);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (MAX_TRANS_DEF + 16) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// ends the run with errors if the test has not finished in time
	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
